FILE: hdl/ske_pkg.sv
// ske_pkg: shared types and constants of the spir-v kernel entry scanner
// no dependencies; imported by ske_core, ske_fifo and the top level
`default_nettype none

package ske_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 20;
  localparam int unsigned FIFO_DEPTH      = 4;

  localparam logic [31:0] MAGIC_WORD   = 32'h0723_0203;
  localparam logic [15:0] OP_ENTRY     = 16'd15;
  localparam logic [31:0] MODEL_KERNEL = 32'd6;
  localparam logic [15:0] HALF_MAX     = 16'hFFFF;
  localparam int unsigned HEADER_WORDS = 5;

  typedef enum logic [1:0] {
    KIND_NAME      = 2'd0,
    KIND_OK        = 2'd1,
    KIND_MALFORMED = 2'd2,
    KIND_NOT_SPIRV = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_SCAN      = 2'd0,
    ST_MALFORMED = 2'd2,
    ST_NOT_SPIRV = 2'd3
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] name_word;
    logic [2:0]  name_bytes;
    logic        name_last;
  } res_t;

  // up to two results per input word, r0 goes out first
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

`default_nettype wire

FILE: hdl/spirv_kernel_entry_scanner_top.sv
// spirv_kernel_entry_scanner_top: top level of the spir-v kernel entry scanner
// depends on ske_pkg, ske_core and ske_fifo
//
// usage:
//   cfg channel: cfg_data_i carries the module length in words; it is taken
//   whenever cfg_valid_i is high (cfg_ready_o is always high). write it only
//   while the block is idle.
//   input stream s_axis: one 32-bit module word per beat, lowest-address byte
//   in bits 7:0. words are counted against the module length; after the
//   last word the scan restarts at word 0 of the next module.
//   output stream m_axis: one result per beat. tuser is the kind (name word,
//   done ok, done malformed, not spir-v), tlast marks a kernel name's final
//   word, tdata holds the name bytes and the valid byte count.
// path: a word waits in the input register, is scanned and pushed into a
//   four-entry result queue, and shows on m_axis from the head of the queue.
// throughput: one word per cycle; the scan state is a handful of counters
//   updated by one compare and add per word. a word that ends a module while
//   emitting a name word pushes two results; the queue drains one per cycle.
// reset: rst_ni low clears the module length, the scan state and the queue.
// stall: when m_axis_tready is low the queue fills; the input register then
//   holds its word and s_axis_tready drops until the queue has two free slots.
`default_nettype none

module spirv_kernel_entry_scanner_top
  import ske_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // configuration write channel
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire [COUNT_WIDTH-1:0] cfg_data_i,   // module_words
  // input word stream
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire  [31:0]           s_axis_tdata,  // [31:0] word
  // result stream
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [39:0]           m_axis_tdata,  // [31:0] name_word, [34:32] name_bytes, zero pad
  output logic [1:0]            m_axis_tuser,  // [1:0] kind
  output logic                  m_axis_tlast   // name_last
);

  push_t push;
  logic  space;
  res_t  head;

  assign cfg_ready_o = 1'b1;

  // scan state machine with its input word register
  ske_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_word_i   (s_axis_tdata),
    .space_i     (space),
    .push_o      (push)
  );

  // result queue decouples the scan from output stalls
  ske_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (head)
  );

  assign m_axis_tdata = {5'd0, head.name_bytes, head.name_word};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.name_last;

endmodule

`default_nettype wire

FILE: hdl/ske_fifo.sv
// ske_fifo: small result queue, takes up to two results per cycle, gives one
// depends on ske_pkg (res_t, push_t, FIFO_DEPTH)
`default_nettype none

module ske_fifo
  import ske_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  push_t push_i,
  output logic  space_o,
  output logic  out_valid_o,
  input  wire   out_ready_i,
  output res_t  out_data_o
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  res_t          mem_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign space_o     = (cnt_q <= CW'(FIFO_DEPTH - 2));

  always_comb begin
    wr_d  = wr_q + PW'(push_i.cnt);
    rd_d  = rd_q + PW'(pop);
    cnt_d = cnt_q + CW'(push_i.cnt) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + PW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ske_core.sv
// ske_core: input word register, scan state and per-word result generation
// depends on ske_pkg (status_e, kind_e, push_t, scan constants)
`default_nettype none

module ske_core
  import ske_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_valid_i,
  input  wire [COUNT_WIDTH-1:0] cfg_data_i,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire  [31:0]           in_word_i,
  input  wire                   space_i,
  output push_t                 push_o
);

  localparam int unsigned LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic [COUNT_WIDTH-1:0] mw_q;
  logic                   vld_q;
  logic [31:0]            word_q;
  logic [COUNT_WIDTH-1:0] pos_q, pos_d;
  logic [15:0]            rem_q, rem_d;
  logic [15:0]            off_q, off_d;
  logic                   kern_q, kern_d;
  logic                   fin_q, fin_d;
  status_e                st_q, st_d;
  status_e                st_upd;

  logic                   fire;
  logic                   last_word;
  logic [15:0]            len;
  logic [COUNT_WIDTH-1:0] avail;
  logic [2:0]             nbytes;
  logic                   zero_found;
  logic [31:0]            masked;
  logic                   emit;
  logic                   name_last;
  res_t                   name_res, stat_res;
  kind_e                  end_kind;

  assign fire       = vld_q && space_i;
  assign in_ready_o = !vld_q || space_i;
  assign len        = word_q[31:16];
  assign avail      = (mw_q > pos_q) ? (mw_q - pos_q) : '0;
  assign last_word  = ({1'b0, pos_q} + 1'b1) >= {1'b0, mw_q};

  // bytes before the first zero byte, later bytes forced to zero
  always_comb begin
    nbytes     = 3'd4;
    zero_found = 1'b0;
    masked     = word_q;
    for (int i = 0; i < 4; i++) begin
      if (!zero_found && word_q[8*i +: 8] == 8'd0) begin
        zero_found = 1'b1;
        nbytes     = 3'(i);
      end
      if (zero_found) begin
        masked[8*i +: 8] = 8'd0;
      end
    end
  end

  always_comb begin
    pos_d  = pos_q;
    rem_d  = rem_q;
    off_d  = off_q;
    kern_d = kern_q;
    fin_d  = fin_q;
    st_d   = st_q;
    emit   = 1'b0;
    if (st_q == ST_SCAN) begin
      if (pos_q == '0) begin
        if (word_q != MAGIC_WORD || mw_q < COUNT_WIDTH'(HEADER_WORDS)) begin
          st_d = ST_NOT_SPIRV;
        end
      end else if (pos_q >= COUNT_WIDTH'(HEADER_WORDS)) begin
        if (rem_q == '0) begin
          if (len == '0 || LW'(len) > LW'(avail)) begin
            st_d = ST_MALFORMED;
          end else begin
            rem_d  = len - 16'd1;
            off_d  = 16'd1;
            kern_d = (word_q[15:0] == OP_ENTRY) && (len >= 16'd4);
            fin_d  = 1'b0;
          end
        end else begin
          if (off_q == 16'd1 && word_q != MODEL_KERNEL) begin
            kern_d = 1'b0;
          end
          if (kern_q && off_q >= 16'd3 && !fin_q) begin
            emit = 1'b1;
            if (zero_found) begin
              fin_d = 1'b1;
            end
          end
          rem_d = rem_q - 16'd1;
          if (off_q != HALF_MAX) begin
            off_d = off_q + 16'd1;
          end
        end
      end
    end
    // status including this word, before the end of module clears it
    st_upd = st_d;
    if (last_word) begin
      pos_d  = '0;
      rem_d  = '0;
      off_d  = '0;
      kern_d = 1'b0;
      fin_d  = 1'b0;
      st_d   = ST_SCAN;
    end else begin
      pos_d = pos_q + 1'b1;
    end
  end

  assign name_last = zero_found || (rem_q == 16'd1);
  assign end_kind  = (mw_q < COUNT_WIDTH'(HEADER_WORDS)) ? KIND_NOT_SPIRV :
                     (st_upd == ST_SCAN) ? KIND_OK : kind_e'(st_upd);

  always_comb begin
    name_res = '{kind: KIND_NAME, name_word: masked, name_bytes: nbytes,
                 name_last: name_last};
    stat_res = '{kind: end_kind, name_word: '0, name_bytes: '0, name_last: 1'b0};
    push_o   = '0;
    if (fire && mw_q != '0) begin
      if (emit && last_word) begin
        push_o.cnt = 2'd2;
        push_o.r0  = name_res;
        push_o.r1  = stat_res;
      end else if (emit) begin
        push_o.cnt = 2'd1;
        push_o.r0  = name_res;
      end else if (last_word) begin
        push_o.cnt = 2'd1;
        push_o.r0  = stat_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mw_q   <= '0;
      vld_q  <= 1'b0;
      pos_q  <= '0;
      rem_q  <= '0;
      off_q  <= '0;
      kern_q <= 1'b0;
      fin_q  <= 1'b0;
      st_q   <= ST_SCAN;
    end else begin
      if (cfg_valid_i) begin
        mw_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
      if (fire && mw_q != '0) begin
        pos_q  <= pos_d;
        rem_q  <= rem_d;
        off_q  <= off_d;
        kern_q <= kern_d;
        fin_q  <= fin_d;
        st_q   <= st_d;
      end
    end
  end

`ifndef ASSERT_OFF
  // a word with two results: the name word first, then the status
  a_two_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd2 |-> push_o.r0.kind == KIND_NAME && push_o.r1.kind != KIND_NAME)
    else $error("two results out of order");

  // a stopped scan is never at word 0 of a module
  a_stop_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ST_SCAN |-> pos_q != '0)
    else $error("scan stopped at module start");

  // an open instruction only exists past the header
  a_rem_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != '0 |-> pos_q > COUNT_WIDTH'(HEADER_WORDS))
    else $error("instruction open inside header");

  // a finished name belongs to a kernel entry
  a_fin_kern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> kern_q)
    else $error("name finished outside kernel entry");

  // no results are pushed without room in the queue
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt != 2'd0 |-> space_i && $past(in_ready_o || vld_q))
    else $error("push without queue room");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// tb_top: self-checking bench for spirv_kernel_entry_scanner_top
// streams spir-v style modules through s_axis, predicts name and status beats in a scoreboard
// depends on ske_pkg and the scanner rtl
module tb_top;
  import ske_pkg::*;

  localparam int unsigned LEN_W         = COUNT_WIDTH_DEF;
  localparam logic [LEN_W-1:0] MAX_LEN  = '1;
  localparam int unsigned WORD_TARGET   = 1250;
  localparam int unsigned QUIET_FROM    = 1100;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned STALL_LIMIT   = 600;

  typedef enum {SHAPE_CLEAN, SHAPE_BAD_MAGIC, SHAPE_BROKEN} shape_e;

  // predicts the scanner beat by beat and checks what comes out
  class entry_point_checker;
    logic [LEN_W-1:0] module_len;
    logic [LEN_W-1:0] word_pos;
    logic [15:0]      words_left;
    logic [15:0]      word_in_instr;
    bit               in_kernel_entry;
    bit               name_done;
    status_e          status;
    res_t             pending_results[$];
    int unsigned      errors;
    int unsigned      seen_kind[4];

    function new();
      module_len = '0;
      restart_module();
    endfunction

    function void restart_module();
      word_pos        = '0;
      words_left      = '0;
      word_in_instr   = '0;
      in_kernel_entry = 1'b0;
      name_done       = 1'b0;
      status          = ST_SCAN;
    endfunction

    function void set_length(logic [LEN_W-1:0] v);
      module_len = v;
    endfunction

    function void push(kind_e k, logic [31:0] w, logic [2:0] nb, logic nl);
      res_t r;
      r.kind       = k;
      r.name_word  = w;
      r.name_bytes = nb;
      r.name_last  = nl;
      pending_results = {pending_results, r};
    endfunction

    // one accepted module word
    function void scan_word(logic [31:0] w);
      int unsigned avail, ilen;
      int          cnt, i;
      logic [31:0] nw;
      logic        last;
      kind_e       done_kind;
      if (module_len == 0) return;
      if (status == ST_SCAN) begin
        if (word_pos == 0) begin
          if (w != MAGIC_WORD || module_len < HEADER_WORDS) status = ST_NOT_SPIRV;
        end else if (word_pos >= HEADER_WORDS) begin
          if (words_left == 0) begin
            // first word of an instruction: length in the upper half
            ilen  = w[31:16];
            avail = (module_len > word_pos) ? int'(module_len - word_pos) : 0;
            if (ilen == 0 || ilen > avail) begin
              status = ST_MALFORMED;
            end else begin
              words_left      = 16'(ilen - 1);
              word_in_instr   = 16'd1;
              in_kernel_entry = (w[15:0] == OP_ENTRY) && (ilen >= 4);
              name_done       = 1'b0;
            end
          end else begin
            if (word_in_instr == 1 && w != MODEL_KERNEL) in_kernel_entry = 1'b0;
            if (in_kernel_entry && word_in_instr >= 3 && !name_done) begin
              cnt = 4;
              for (i = 3; i >= 0; i--) if (w[8*i +: 8] == 8'h00) cnt = i;
              nw = w;
              for (i = 0; i < 4; i++) if (i >= cnt) nw[8*i +: 8] = 8'h00;
              if (cnt < 4) begin
                name_done = 1'b1;
                last      = 1'b1;
              end else begin
                last = (words_left == 1);
              end
              push(KIND_NAME, nw, 3'(cnt), last);
            end
            words_left = words_left - 16'd1;
            if (word_in_instr < HALF_MAX) word_in_instr = word_in_instr + 16'd1;
          end
        end
      end
      if (int'(word_pos) + 1 >= int'(module_len)) begin
        if (module_len < HEADER_WORDS) done_kind = KIND_NOT_SPIRV;
        else if (status == ST_SCAN)    done_kind = KIND_OK;
        else                           done_kind = kind_e'(status);
        push(done_kind, 32'h0, 3'd0, 1'b0);
        restart_module();
      end else begin
        word_pos = word_pos + 1'b1;
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("tb_top: mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [1:0] kind, logic [31:0] nw, logic [2:0] nb, logic nl);
      res_t exp;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d word %h", kind, nw));
        return;
      end
      exp = pending_results.pop_front();
      seen_kind[kind]++;
      if (kind !== exp.kind)
        report_mismatch($sformatf("kind %0d, want %0d", kind, exp.kind));
      if (nw !== exp.name_word)
        report_mismatch($sformatf("name_word %h, want %h", nw, exp.name_word));
      if (nb !== exp.name_bytes)
        report_mismatch($sformatf("name_bytes %0d, want %0d", nb, exp.name_bytes));
      if (nl !== exp.name_last)
        report_mismatch($sformatf("name_last %0d, want %0d", nl, exp.name_last));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [LEN_W-1:0] cfg_data_i    = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [39:0]      m_axis_tdata;   // [31:0] name_word, [34:32] name_bytes
  logic [1:0]       m_axis_tuser;   // [1:0] kind
  logic             m_axis_tlast;

  entry_point_checker board = new();
  logic [31:0] words_q[$];
  int unsigned scanned_words;
  int unsigned length_writes;
  int unsigned stalled_cycles;
  int unsigned sender_calm;
  bit          quiet;

  spirv_kernel_entry_scanner_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side: stall bursts mixed with calm stretches, always ready near the end
  initial begin
    int unsigned stall_left, calm_left;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (calm_left != 0) begin
        m_axis_tready <= 1'b1;
        calm_left--;
      end else begin
        if ($urandom_range(0, 2) == 0) calm_left = $urandom_range(10, 60);
        else stall_left = $urandom_range(1, 11);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("tb_top: watchdog expired with %0d results outstanding",
               board.pending_results.size());
      $display("tb_top: FAIL");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  task automatic send_word(logic [31:0] w);
    int unsigned gap;
    @(negedge clk_i);
    if (sender_calm != 0) begin
      sender_calm--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end else if ($urandom_range(0, 5) == 0) begin
      sender_calm = $urandom_range(8, 48);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    if (board.module_len != 0) scanned_words++;
    board.scan_word(w);
  endtask

  // stop sending and let every predicted beat come out, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length(logic [LEN_W-1:0] v);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_length(v);
    length_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_module(int unsigned count, bit pause_midway);
    for (int k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) drain_results();
      send_word(words_q[k]);
    end
  endtask

  function automatic logic [31:0] name_chars();
    return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
            8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
  endfunction

  // append one word to the module being built
  function automatic void add_word(logic [31:0] w);
    words_q = {words_q, w};
  endfunction

  // header, then a chain of instructions that fills len words exactly
  function automatic void build_module(int unsigned len, shape_e shape);
    int unsigned rem, ilen, nwords, term_at, zpos, break_at, pick;
    logic [31:0] w;
    words_q.delete();
    if (shape == SHAPE_BAD_MAGIC) begin
      w = $urandom;
      if (w == MAGIC_WORD) w[0] = ~w[0];
      add_word(w);
    end else begin
      add_word(MAGIC_WORD);
    end
    while (words_q.size() < len && words_q.size() < HEADER_WORDS) add_word($urandom);
    break_at = (len > HEADER_WORDS) ? $urandom_range(HEADER_WORDS, len - 1) : len;
    while (words_q.size() < len) begin
      rem  = len - words_q.size();
      pick = $urandom_range(0, 9);
      if (shape == SHAPE_BROKEN && words_q.size() >= break_at) begin
        // zero length or one that runs past the module end
        if ($urandom_range(0, 2) == 0)      ilen = 0;
        else if ($urandom_range(0, 1) == 0) ilen = rem + 1;
        else                                ilen = $urandom_range(rem + 1, 16'hFFFF);
        add_word({16'(ilen), 16'($urandom)});
        while (words_q.size() < len) add_word($urandom);
      end else if (rem >= 4 && pick < 6) begin
        ilen = $urandom_range(4, (rem < 12) ? rem : 12);
        add_word({16'(ilen), OP_ENTRY});
        add_word((pick == 0) ? 32'($urandom) : MODEL_KERNEL);
        add_word($urandom);
        nwords  = ilen - 3;
        term_at = $urandom_range(0, nwords);  // nwords means no terminator
        for (int k = 0; k < nwords; k++) begin
          w = name_chars();
          if (k == term_at) begin
            zpos = $urandom_range(0, 3);
            w[8*zpos +: 8] = 8'h00;
            for (int j = 0; j < 4; j++) if (j > zpos) w[8*j +: 8] = 8'($urandom);
          end else if (k > term_at) begin
            w = $urandom;
          end
          add_word(w);
        end
      end else if (rem >= 3 && pick == 6) begin
        // entry point too short to carry a name
        add_word({16'd3, OP_ENTRY});
        add_word(MODEL_KERNEL);
        add_word($urandom);
      end else begin
        ilen = $urandom_range(1, (rem < 8) ? rem : 8);
        add_word({16'(ilen), 16'($urandom)});
        for (int k = 1; k < ilen; k++) add_word($urandom);
      end
    end
  endfunction

  initial begin
    int unsigned pick, len, n_mod, count, phase;
    shape_e shape;
    scanned_words = 0;
    length_writes = 0;
    sender_calm   = 0;
    quiet         = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero length ignores everything
    write_length('0);
    words_q = '{32'hFFFF_FFFF, 32'h0000_0000};
    send_module(2, 1'b0);
    // module shorter than the header
    write_length(3);
    words_q = '{MAGIC_WORD, 32'h0000_0000, 32'hFFFF_FFFF};
    send_module(3, 1'b0);
    // wrong magic
    write_length(5);
    words_q = '{MAGIC_WORD ^ 32'h1, 32'h0, 32'h0, 32'h0, 32'h0};
    send_module(5, 1'b0);
    // two kernel names: one cut by a zero byte with a trailing word, one running
    // to the end of its instruction on the last module word
    write_length(14);
    words_q = '{MAGIC_WORD, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                {16'd5, OP_ENTRY}, MODEL_KERNEL, 32'h1, 32'h6362_0061, 32'hFFFF_FFFF,
                {16'd4, OP_ENTRY}, MODEL_KERNEL, 32'h2, 32'h6463_6261};
    send_module(14, 1'b0);
    // zero-length instruction stops the scan
    write_length(6);
    words_q = '{MAGIC_WORD, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0000_0011};
    send_module(6, 1'b0);

    // random phases, each under one module length
    phase = 0;
    while (scanned_words < WORD_TARGET) begin
      quiet = (scanned_words >= QUIET_FROM);
      pick  = $urandom_range(0, 99);
      if (phase == 0 || pick < 3) begin
        // longest length: the module stays open and the next write cuts it short
        write_length(MAX_LEN);
        build_module($urandom_range(6, 40), SHAPE_CLEAN);
        send_module(words_q.size(), phase == 0);
      end else if (pick < 7) begin
        write_length('0);
        repeat (3) send_word($urandom);
      end else begin
        if (pick < 14)      len = $urandom_range(1, 4);
        else if (pick < 24) len = $urandom_range(25, 120);
        else                len = $urandom_range(5, 24);
        write_length(LEN_W'(len));
        n_mod = $urandom_range(1, 4);
        for (int m = 0; m < n_mod; m++) begin
          pick = $urandom_range(0, 19);
          if (pick < 15)      shape = SHAPE_CLEAN;
          else if (pick < 17) shape = SHAPE_BAD_MAGIC;
          else                shape = SHAPE_BROKEN;
          build_module(len, shape);
          count = len;
          if (m == n_mod - 1 && len > 1 && $urandom_range(0, 9) == 0)
            count = $urandom_range(1, len - 1);
          send_module(count, $urandom_range(0, 19) == 0);
        end
      end
      phase++;
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("tb_top: %0d module words over %0d length writes, %0d name words checked",
             scanned_words, length_writes, board.seen_kind[KIND_NAME]);
    $display("tb_top: module ends seen: %0d ok, %0d malformed, %0d not spir-v, %0d mismatches",
             board.seen_kind[KIND_OK], board.seen_kind[KIND_MALFORMED],
             board.seen_kind[KIND_NOT_SPIRV], board.errors);
    if (board.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ske_pkg.sv
hdl/ske_fifo.sv
hdl/ske_core.sv
hdl/spirv_kernel_entry_scanner_top.sv
bench/tb_top.sv
